/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/tts_pkg.sv */
// Types and constants of the timed task sequencer.
`timescale 1ns / 1ps
package tts_pkg;

  localparam int unsigned IdW   = 8;
  localparam int unsigned DurW  = 24;
  localparam int unsigned StepW = 10;
  localparam int unsigned QW    = 9;

  localparam logic [StepW-1:0] TickStepReset = 10'd10;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_RUN   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]      command;
    logic [IdW-1:0]  task_id;
    logic [DurW-1:0] duration;
  } in_t;

  typedef struct packed {
    logic            accepted;
    logic            fire;
    logic [IdW-1:0]  fire_task;
    logic            finished;
    logic [QW-1:0]   queued;
  } out_t;

  typedef struct packed {
    logic [IdW-1:0]  task_id;
    logic [DurW-1:0] duration;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

/* rtl/timed_task_sequencer.sv */
// Top level of the timed task sequencer: command decode, current task and the cell row.
`timescale 1ns / 1ps
// Each command accepted on start is finished in the cycle that takes it, and its single
// result word appears with result_valid_o in the following cycle, so one command per clock
// is sustained and busy never rises. The queue is a cell row that shifts to the head on
// every tick that loads a task and loads at the entry count's cell on an add or at the
// head on a run. Results cannot be held off and must be taken in the cycle they are shown.
module timed_task_sequencer #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  tts_pkg::in_t               cmd_i,
  output logic                       result_valid_o,
  output tts_pkg::out_t              res_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [tts_pkg::StepW-1:0]  cfg_data_i
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [tts_pkg::IdW-1:0]    cur_q, cur_d;
  logic [tts_pkg::DurW-1:0]   tl_q, tl_d;
  logic [tts_pkg::StepW-1:0]  step_q;
  logic                       rv_q;
  tts_pkg::out_t              res_q, res_d;

  logic                       take;
  logic                       push, pop;
  logic [CntW-1:0]            push_idx;
  logic [tts_pkg::DurW-1:0]   tl_src, step_ext;
  tts_pkg::entry_t            new_word;
  tts_pkg::entry_t            words [QUEUE_DEPTH];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign take        = start && !busy;
  assign new_word    = '{task_id: cmd_i.task_id, duration: cmd_i.duration};
  assign step_ext    = {{(tts_pkg::DurW - tts_pkg::StepW){1'b0}}, step_q};

  always_comb begin
    cnt_d    = cnt_q;
    cur_d    = cur_q;
    tl_d     = tl_q;
    push     = 1'b0;
    pop      = 1'b0;
    push_idx = cnt_q;
    tl_src   = tl_q;
    res_d    = '0;
    res_d.accepted = 1'b1;
    case (tts_pkg::cmd_e'(cmd_i.command))
      tts_pkg::CMD_ADD: begin
        if (cnt_q == CntW'(QUEUE_DEPTH)) begin
          res_d.accepted = 1'b0;
        end else begin
          push  = 1'b1;
          cnt_d = cnt_q + CntW'(1);
        end
      end
      tts_pkg::CMD_CLEAR: begin
        cnt_d = '0;
        cur_d = '0;
        tl_d  = '0;
      end
      tts_pkg::CMD_RUN: begin
        push     = 1'b1;
        push_idx = '0;
        cnt_d    = CntW'(1);
        cur_d    = '0;
        tl_d     = '0;
      end
      tts_pkg::CMD_TICK: begin
        if (tl_q != '0) begin
          res_d.fire      = cur_q != '0;
          res_d.fire_task = cur_q;
          tl_d = (tl_q > step_ext) ? tl_q - step_ext : '0;
        end else if (cnt_q != '0) begin
          pop    = 1'b1;
          cnt_d  = cnt_q - CntW'(1);
          cur_d  = words[0].task_id;
          tl_src = words[0].duration;
          res_d.fire      = words[0].task_id != '0;
          res_d.fire_task = words[0].task_id;
          tl_d = (tl_src > step_ext) ? tl_src - step_ext : '0;
        end else begin
          cur_d = '0;
        end
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
    res_d.finished = (tl_d == '0) && (cnt_d == '0);
    res_d.queued   = tts_pkg::QW'(cnt_d);
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    tts_pkg::cell_ctrl_t ctrl;
    tts_pkg::entry_t     next_word;
    assign ctrl = '{shift: take && pop,
                    load:  take && push && (push_idx == CntW'(i))};
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_word = words[i];
    end else begin : g_mid
      assign next_word = words[i+1];
    end
    tts_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .new_i  (new_word),
      .next_i (next_word),
      .word_o (words[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      cur_q  <= '0;
      tl_q   <= '0;
      step_q <= tts_pkg::TickStepReset;
      rv_q   <= 1'b0;
    end else begin
      rv_q <= take;
      if (take) begin
        cnt_q <= cnt_d;
        cur_q <= cur_d;
        tl_q  <= tl_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        step_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign result_valid_o = rv_q;
  assign res_o          = res_q;

endmodule

/* rtl/tts_cell.sv */
// One cell of the task queue, holding a single queued entry.
`timescale 1ns / 1ps
module tts_cell (
  input  logic                clk_i,
  input  tts_pkg::cell_ctrl_t ctrl_i,
  input  tts_pkg::entry_t     new_i,
  input  tts_pkg::entry_t     next_i,
  output tts_pkg::entry_t     word_o
);

  tts_pkg::entry_t word_q, word_d;

  always_comb begin
    word_d = word_q;
    if (ctrl_i.shift) begin
      word_d = next_i;
    end else if (ctrl_i.load) begin
      word_d = new_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

/* rtl/tts_checker.sv */
// Port-level checker for the timed task sequencer and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tts_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic                       result_valid_o,
  input tts_pkg::out_t              res_o
);

  `ASSERT_NEXT(a_word_follows, clk_i, rst_ni, start && !busy, result_valid_o)
  `ASSERT_NEXT(a_no_phantom, clk_i, rst_ni, !(start && !busy), !result_valid_o)
  `ASSERT_IMPLIES(a_fire_id, clk_i, rst_ni, result_valid_o && res_o.fire, res_o.fire_task != '0)
  `ASSERT_IMPLIES(a_fire_ok, clk_i, rst_ni, result_valid_o && res_o.fire, res_o.accepted)
  `ASSERT_IMPLIES(a_fin_empty, clk_i, rst_ni, result_valid_o && res_o.queued != '0,
                  !res_o.finished)

endmodule

bind timed_task_sequencer tts_checker u_tts_checker (.*);
